// ----- rtl/trn_pkg.sv -----
// shared types and constants for the telnet receive negotiator
package trn_pkg;
   localparam logic [7:0] T_SE   = 8'd240;
   localparam logic [7:0] T_SB   = 8'd250;
   localparam logic [7:0] T_WILL = 8'd251;
   localparam logic [7:0] T_WONT = 8'd252;
   localparam logic [7:0] T_DO   = 8'd253;
   localparam logic [7:0] T_DONT = 8'd254;
   localparam logic [7:0] T_IAC  = 8'd255;
   localparam logic [7:0] OPT_STATUS = 8'd5;
   localparam logic [7:0] OPT_TTYPE  = 8'd24;
   localparam logic [7:0] OPT_NAWS   = 8'd31;
   localparam logic [63:0] WANTED_RESET = 64'h0000_0004_8100_002A;

   localparam logic [1:0] KIND_APP  = 2'd0;
   localparam logic [1:0] KIND_PEER = 2'd1;
   localparam logic [1:0] KIND_WIN  = 2'd2;

   typedef enum logic [2:0] {
      M_DATA, M_IAC, M_SB, M_WILL, M_WONT, M_DO, M_DONT
   } mode_type;

   typedef enum logic [1:0] {
      J_APP, J_NAWS, J_NEG
   } job_kind_type;

   // job passed from front to back
   typedef struct packed {
      job_kind_type kind;
      mode_type     mode;
      logic [7:0]   data;
   } job_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [15:0] win_width;
      logic [15:0] win_height;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      B_IDLE, B_SEARCH, B_DECIDE, B_EMIT, B_NAWS
   } back_state_type;
endpackage

// ----- rtl/trn_if.sv -----
// valid/ready channel interfaces
interface trn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface trn_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic [15:0] win_width;
   logic [15:0] win_height;
   logic        last;
   modport source (output valid, output out_kind, output out_byte, output win_width,
                   output win_height, output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input win_width,
                 input win_height, input last, output ready);
endinterface

// ----- rtl/trn_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
module trn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/trn_front.sv -----
// front end: mode tracking, subnegotiation capture, job issue
module trn_front #(
   parameter int SUB_BUFFER_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   output logic              job_valid,
   input  logic              job_ready,
   output trn_pkg::job_type  job,
   input  logic              naws_done,
   output logic              sub_wr,
   output logic [$clog2(SUB_BUFFER_BYTES)-1:0] sub_addr,
   output logic [7:0]        sub_data
);
   import trn_pkg::*;
   localparam int CW = $clog2(SUB_BUFFER_BYTES + 1);

   mode_type mode_ff, mode_in;
   logic [7:0] code_ff, code_in;
   logic started_ff, started_in;
   logic [CW-1:0] count_ff, count_in;
   logic pend_ff, pend_in;

   logic fire;
   // hold input while a window size job still has to read the capture
   assign in_ready = job_ready && !pend_ff;
   assign fire = in_valid && in_ready;
   assign sub_addr = count_ff[$clog2(SUB_BUFFER_BYTES)-1:0];
   assign sub_data = in_byte;

   always_comb begin
      mode_in = mode_ff;
      code_in = code_ff;
      started_in = started_ff;
      count_in = count_ff;
      pend_in = pend_ff;
      job_valid = 1'b0;
      job = '{kind: J_APP, mode: mode_ff, data: in_byte};
      sub_wr = 1'b0;
      if (naws_done) begin
         pend_in = 1'b0;
      end
      if (fire) begin
         unique case (mode_ff)
            M_DATA: begin
               if (in_byte == T_IAC) begin
                  mode_in = M_IAC;
               end else begin
                  job_valid = 1'b1;
               end
            end
            M_IAC: begin
               mode_in = M_DATA;
               priority if (in_byte == T_SB) begin
                  mode_in = M_SB;
               end else if (in_byte == T_WILL) begin
                  mode_in = M_WILL;
               end else if (in_byte == T_WONT) begin
                  mode_in = M_WONT;
               end else if (in_byte == T_DO) begin
                  mode_in = M_DO;
               end else if (in_byte == T_DONT) begin
                  mode_in = M_DONT;
               end else if (in_byte == T_IAC) begin
                  job_valid = 1'b1;
               end else if (in_byte == T_SE) begin
                  if (started_ff && code_ff == OPT_NAWS) begin
                     job_valid = 1'b1;
                     job.kind = J_NAWS;
                     pend_in = 1'b1;
                  end
                  started_in = 1'b0;
                  count_in = '0;
                  code_in = '0;
               end else begin
               end
            end
            M_SB: begin
               priority if (in_byte == T_IAC) begin
                  mode_in = M_IAC;
               end else if (!started_ff) begin
                  code_in = in_byte;
                  started_in = 1'b1;
                  count_in = '0;
               end else if (count_ff < CW'(SUB_BUFFER_BYTES)) begin
                  sub_wr = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
               end
            end
            M_WILL, M_WONT, M_DO, M_DONT: begin
               job_valid = 1'b1;
               job.kind = J_NEG;
               mode_in = M_DATA;
            end
            default: mode_in = M_DATA;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_DATA;
         code_ff <= '0;
         started_ff <= 1'b0;
         count_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         code_ff <= code_in;
         started_ff <= started_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
      end
   end
endmodule

// ----- rtl/trn_queue.sv -----
// two entry job queue between front and back
module trn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  trn_pkg::job_type wr_job,
   output logic             rd_valid,
   input  logic             rd_ready,
   output trn_pkg::job_type rd_job
);
   import trn_pkg::*;
   job_type slot_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_job = slot_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ----- rtl/trn_back.sv -----
// back end: option table search, reply sequencing, window size decode
module trn_back #(
   parameter int TABLE_ENTRIES = 16,
   parameter int SUB_BUFFER_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [63:0]      wanted,
   input  logic             job_valid,
   output logic             job_ready,
   input  trn_pkg::job_type job,
   output logic             naws_done,
   output logic [$clog2(SUB_BUFFER_BYTES)-1:0] rd_addr,
   input  logic [7:0]       rd_data,
   output logic             out_valid,
   input  logic             out_ready,
   output trn_pkg::rsp_type out_data
);
   import trn_pkg::*;
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW = $clog2(SUB_BUFFER_BYTES);

   back_state_type state_ff, state_in;
   job_type job_ff, job_in;
   logic [TABLE_ENTRIES-1:0] ent_valid_ff, ent_valid_in;
   logic [TABLE_ENTRIES-1:0] ent_en_ff, ent_en_in;
   logic [7:0] ent_code_ff [TABLE_ENTRIES];
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic hit_ff, hit_in;
   logic [3:0] seq_ff, seq_in;
   logic req_ff, req_in;
   logic rep_ff, rep_in;
   logic [7:0] reply_ff, reply_in;
   logic [2:0] nidx_ff, nidx_in;
   logic [7:0] nb_ff [4];
   logic code_wr;
   logic [IW-1:0] code_idx;
   rsp_type obuf_ff, obuf_in;
   logic ovalid_ff, ovalid_in;
   logic obuf_free;

   logic found, free_found;
   logic [IW-1:0] found_idx, free_idx;
   logic desired;

   assign out_valid = ovalid_ff;
   assign out_data = obuf_ff;
   assign obuf_free = !ovalid_ff || out_ready;
   assign rd_addr = SW'(nidx_ff[1:0]);

   always_comb begin
      found = 1'b0;
      found_idx = '0;
      free_found = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (ent_valid_ff[i] && ent_code_ff[i] == job_ff.data) begin
            found = 1'b1;
            found_idx = IW'(i);
         end
         if (!ent_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign desired = !job_ff.data[7] && !job_ff.data[6] && wanted[job_ff.data[5:0]];

   always_comb begin
      logic [7:0] b;
      logic fin;
      logic [7:0] affirm, negate;
      b = '0;
      fin = 1'b0;
      state_in = state_ff;
      job_in = job_ff;
      ent_valid_in = ent_valid_ff;
      ent_en_in = ent_en_ff;
      hit_idx_in = hit_idx_ff;
      hit_in = hit_ff;
      seq_in = seq_ff;
      req_in = req_ff;
      rep_in = rep_ff;
      reply_in = reply_ff;
      nidx_in = nidx_ff;
      code_wr = 1'b0;
      code_idx = free_idx;
      obuf_in = obuf_ff;
      ovalid_in = ovalid_ff && !out_ready;
      job_ready = 1'b0;
      naws_done = 1'b0;
      affirm = (job_ff.mode == M_WILL || job_ff.mode == M_WONT) ? T_DO : T_WILL;
      negate = (job_ff.mode == M_WILL || job_ff.mode == M_WONT) ? T_DONT : T_WONT;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               unique case (job.kind)
                  J_APP: begin
                     if (obuf_free) begin
                        job_ready = 1'b1;
                        ovalid_in = 1'b1;
                        obuf_in = '{out_kind: KIND_APP, out_byte: job.data,
                                    win_width: '0, win_height: '0, last: 1'b1};
                     end
                  end
                  J_NAWS: begin
                     job_ready = 1'b1;
                     job_in = job;
                     nidx_in = '0;
                     state_in = B_NAWS;
                  end
                  default: begin
                     job_ready = 1'b1;
                     job_in = job;
                     state_in = B_SEARCH;
                  end
               endcase
            end
         end
         B_SEARCH: begin
            hit_in = found || free_found;
            hit_idx_in = found ? found_idx : free_idx;
            if (!found && free_found) begin
               ent_valid_in[free_idx] = 1'b1;
               ent_en_in[free_idx] = 1'b0;
               code_wr = 1'b1;
            end
            state_in = B_DECIDE;
         end
         B_DECIDE: begin
            req_in = job_ff.mode == M_WILL &&
                     (job_ff.data == OPT_STATUS || job_ff.data == OPT_TTYPE);
            rep_in = 1'b0;
            reply_in = negate;
            if (job_ff.mode == M_WILL || job_ff.mode == M_DO) begin
               if (!ent_en_ff[hit_idx_ff]) begin
                  rep_in = 1'b1;
                  if (desired) begin
                     reply_in = affirm;
                     ent_en_in[hit_idx_ff] = 1'b1;
                  end
               end
            end else if (ent_en_ff[hit_idx_ff]) begin
               rep_in = 1'b1;
               ent_en_in[hit_idx_ff] = 1'b0;
            end
            if (!hit_ff) begin
               req_in = 1'b0;
               rep_in = 1'b0;
               ent_en_in = ent_en_ff;
            end
            seq_in = req_in ? 4'd0 : 4'd6;
            state_in = (req_in || rep_in) ? B_EMIT : B_IDLE;
         end
         B_EMIT: begin
            if (obuf_free) begin
               unique case (seq_ff)
                  4'd0, 4'd4, 4'd6: b = T_IAC;
                  4'd1: b = T_SB;
                  4'd2, 4'd8: b = job_ff.data;
                  4'd3: b = 8'd1;
                  4'd5: b = T_SE;
                  4'd7: b = reply_ff;
                  default: b = '0;
               endcase
               fin = (seq_ff == 4'd8) || (seq_ff == 4'd5 && !rep_ff);
               ovalid_in = 1'b1;
               obuf_in = '{out_kind: KIND_PEER, out_byte: b,
                           win_width: '0, win_height: '0, last: fin};
               seq_in = seq_ff + 4'd1;
               if (fin) begin
                  state_in = B_IDLE;
               end
            end
         end
         B_NAWS: begin
            if (nidx_ff != 3'd5) begin
               nidx_in = nidx_ff + 3'd1;
            end else if (obuf_free) begin
               ovalid_in = 1'b1;
               obuf_in = '{out_kind: KIND_WIN, out_byte: '0,
                           win_width: {nb_ff[0], nb_ff[1]},
                           win_height: {nb_ff[2], nb_ff[3]}, last: 1'b1};
               naws_done = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (code_wr) begin
         ent_code_ff[code_idx] <= job_ff.data;
      end
      if (state_ff == B_NAWS && nidx_ff != 3'd0 && nidx_ff != 3'd5) begin
         nb_ff[nidx_ff[1:0] - 2'd1] <= rd_data;
      end
      job_ff <= job_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff <= hit_in;
      seq_ff <= seq_in;
      req_ff <= req_in;
      rep_ff <= rep_in;
      reply_ff <= reply_in;
      obuf_ff <= obuf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         ent_valid_ff <= '0;
         ent_en_ff <= '0;
         ovalid_ff <= 1'b0;
         nidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ent_valid_ff <= ent_valid_in;
         ent_en_ff <= ent_en_in;
         ovalid_ff <= ovalid_in;
         nidx_ff <= nidx_in;
      end
   end
endmodule

// ----- rtl/telnet_receive_negotiator_core.sv -----
// top level of the telnet receive negotiator
// plain data: via job queue and output buffer, one per cycle while back idle and rsp ready
// negotiation: via search, decide, emit states; up to 9 bytes, one per cycle if rsp ready
// window size update: sent after the iac se transfer, set by four ram reads
// input holds while a window size update is pending or the job queue is full
// reset is synchronous active high; clears modes, queue, option table valid bits
module telnet_receive_negotiator_core #(
   parameter int TABLE_ENTRIES = 16,
   parameter int SUB_BUFFER_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   trn_req_if.sink     req,
   trn_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import trn_pkg::*;
   localparam int SW = $clog2(SUB_BUFFER_BYTES);

   logic [63:0] wanted_ff;
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;
   logic naws_done;
   logic sub_wr;
   logic [SW-1:0] sub_addr, rd_addr;
   logic [7:0] sub_data, rd_data;
   rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= WANTED_RESET;
      end else if (csr_wr_en) begin
         wanted_ff <= csr_wr_data;
      end
   end

   trn_front #(.SUB_BUFFER_BYTES(SUB_BUFFER_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_byte(req.rx_byte),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj),
      .naws_done(naws_done),
      .sub_wr(sub_wr), .sub_addr(sub_addr), .sub_data(sub_data)
   );

   trn_ram #(.WIDTH(8), .DEPTH(SUB_BUFFER_BYTES)) u_ram (
      .clock(clock), .wr_en(sub_wr), .wr_addr(sub_addr), .wr_data(sub_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   trn_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
   );

   trn_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .SUB_BUFFER_BYTES(SUB_BUFFER_BYTES)) u_back (
      .clock(clock), .reset(reset), .wanted(wanted_ff),
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .naws_done(naws_done),
      .rd_addr(rd_addr), .rd_data(rd_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp_data)
   );

   assign rsp.out_kind = rsp_data.out_kind;
   assign rsp.out_byte = rsp_data.out_byte;
   assign rsp.win_width = rsp_data.win_width;
   assign rsp.win_height = rsp_data.win_height;
   assign rsp.last = rsp_data.last;
endmodule
